>>> rtl/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, always checked (used for reset behavior).
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/pwbd_pkg.sv
// Shared types and constants for the pulse-width byte demodulator.
// No dependencies; imported by the top level, pwbd_cfg and pwbd_framer.
`default_nettype none

package pwbd_pkg;

  localparam int COUNT_WIDTH = 12;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam int THR_W     = 12;
  localparam int NBYTES_W  = 7;
  localparam int BITPOS_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES = 2'd3;

  localparam logic [THR_W-1:0]    LOW_THR_RST   = 12'd9;
  localparam logic [THR_W-1:0]    MID_THR_RST   = 12'd16;
  localparam logic [THR_W-1:0]    HIGH_THR_RST  = 12'd22;
  localparam logic [NBYTES_W-1:0] MAX_BYTES_RST = 7'd50;

  // preamble: at least five zeros then a one (position counts the one too)
  localparam logic [BITPOS_W-1:0] PREAMBLE_MIN = 4'd6;
  localparam logic [BITPOS_W-1:0] DATA_BITS    = 4'd8;
  localparam logic [BITPOS_W-1:0] BITPOS_MAX   = 4'd15;

  typedef struct packed {
    logic [THR_W-1:0]    low_thr;
    logic [THR_W-1:0]    mid_thr;
    logic [THR_W-1:0]    high_thr;
    logic [NBYTES_W-1:0] max_bytes;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       end_of_message;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/pulse_width_byte_demodulator.sv
// Top level of the pulse-width byte demodulator: stream ports, input and
// result registers. Depends on pwbd_pkg, pwbd_cfg and pwbd_framer.
//
//  channel | direction | tdata (low bit first)  | tuser
//  --------+-----------+------------------------+----------------
//  in_     | slave     | [7:0] sample           | -
//  out_    | master    | [7:0] data_byte        | [0] end_of_message
//  cfg_    | write     | cfg_data by cfg_index  | -
//
// One item per cycle sustained while the result is not stalled. An accepted
// sample is held in the input register; the framer step and the result
// register load then happen in the same cycle.
// Reset (rst_n low, synchronous) clears the framer, empties both registers
// and restores register defaults. A stalled result holds the pipeline;
// in_tready drops only when the input register is full and the result
// register cannot drain.
`default_nettype none

module pulse_width_byte_demodulator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] sample
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  output      logic [7:0]                     out_tdata,  // [7:0] data_byte
  output      logic [0:0]                     out_tuser,  // [0] end_of_message
  input  wire logic                           cfg_we,
  input  wire logic [pwbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pwbd_pkg::CFG_DAT_W-1:0] cfg_data
);
  import pwbd_pkg::*;

  cfg_t    cfg;
  result_t res;

  logic       s1_valid_r;
  logic       s1_level_r;     // only the line level (sample bit 7) is kept
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_eom_r;

  logic       advance;        // result register free or draining
  logic       step;           // framer consumes the held item

  assign advance   = !out_valid_r || out_tready;
  assign step      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  pwbd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwbd_framer u_framer (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .level (s1_level_r),
    .cfg   (cfg),
    .res   (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_level_r <= in_tdata[7];
    end
  end

  // result register; an item that makes no result just leaves it empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_data_r <= res.data_byte;
      out_eom_r  <= res.end_of_message;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_eom_r;

endmodule

`default_nettype wire

>>> rtl/pwbd_cfg.sv
// Configuration register file for the demodulator.
// Depends on pwbd_pkg.
`default_nettype none

module pwbd_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [pwbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pwbd_pkg::CFG_DAT_W-1:0] cfg_data,
  output pwbd_pkg::cfg_t                     cfg
);
  import pwbd_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_thr   <= LOW_THR_RST;
      cfg_r.mid_thr   <= MID_THR_RST;
      cfg_r.high_thr  <= HIGH_THR_RST;
      cfg_r.max_bytes <= MAX_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_THR:   cfg_r.low_thr   <= cfg_data[THR_W-1:0];
        REG_MID_THR:   cfg_r.mid_thr   <= cfg_data[THR_W-1:0];
        REG_HIGH_THR:  cfg_r.high_thr  <= cfg_data[THR_W-1:0];
        REG_MAX_BYTES: cfg_r.max_bytes <= cfg_data[NBYTES_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/pwbd_framer.sv
// Pulse measurement, preamble sync and byte framing with even parity.
// Depends on pwbd_pkg. One level sample processed per step.
`default_nettype none

module pwbd_framer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic            level,
  input  wire pwbd_pkg::cfg_t  cfg,
  output pwbd_pkg::result_t    res
);
  import pwbd_pkg::*;

  logic                   prev_r,   prev_nxt;
  logic [COUNT_WIDTH-1:0] plen_r,   plen_nxt;
  logic [BITPOS_W-1:0]    bitpos_r, bitpos_nxt;
  logic                   sync_r,   sync_nxt;
  logic [7:0]             shift_r,  shift_nxt;
  logic [NBYTES_W-1:0]    nbytes_r, nbytes_nxt;

  logic                   pulse_bad;
  logic                   pulse_bit;
  logic [BITPOS_W-1:0]    pos_inc;
  logic [BITPOS_W-1:0]    pos_sat;
  logic                   fr_reset;

  assign pulse_bad = (plen_r < cfg.low_thr) || (plen_r > cfg.high_thr);
  assign pulse_bit = (plen_r >= cfg.mid_thr);
  assign pos_inc   = bitpos_r + 1'b1;
  assign pos_sat   = (bitpos_r < BITPOS_MAX) ? pos_inc : bitpos_r;

  always_comb begin
    prev_nxt   = prev_r;
    plen_nxt   = plen_r;
    bitpos_nxt = bitpos_r;
    sync_nxt   = sync_r;
    shift_nxt  = shift_r;
    nbytes_nxt = nbytes_r;
    fr_reset   = 1'b0;
    res        = '0;

    if (step) begin
      if (level == prev_r) begin
        if (plen_r != CNT_MAX) plen_nxt = plen_r + 1'b1;
      end else begin
        prev_nxt = level;
        plen_nxt = '0;
        if (!level) begin
          // falling edge: judge the high pulse
          priority if (pulse_bad) begin
            fr_reset = 1'b1;
          end else if (!sync_r) begin
            bitpos_nxt = pos_sat;
            if (pulse_bit) begin
              if (pos_sat < PREAMBLE_MIN) begin
                fr_reset = 1'b1;
              end else begin
                bitpos_nxt = '0;
                sync_nxt   = 1'b1;
              end
            end
          end else if (pos_inc <= DATA_BITS) begin
            bitpos_nxt = pos_inc;
            shift_nxt  = {shift_r[6:0], pulse_bit};
          end else if ((^shift_r) != pulse_bit) begin
            fr_reset = 1'b1;           // parity error
          end else if (nbytes_r >= cfg.max_bytes) begin
            fr_reset = 1'b1;           // message too long
          end else begin
            nbytes_nxt         = nbytes_r + 1'b1;
            bitpos_nxt         = '0;
            res.valid          = 1'b1;
            res.data_byte      = shift_r;
            res.end_of_message = 1'b0;
          end
        end
      end

      if (fr_reset) begin
        if (nbytes_r != '0) begin
          res.valid          = 1'b1;
          res.data_byte      = '0;
          res.end_of_message = 1'b1;
        end
        prev_nxt   = 1'b0;
        plen_nxt   = '0;
        bitpos_nxt = '0;
        sync_nxt   = 1'b0;
        shift_nxt  = '0;
        nbytes_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= 1'b0;
      plen_r   <= '0;
      bitpos_r <= '0;
      sync_r   <= 1'b0;
      shift_r  <= '0;
      nbytes_r <= '0;
    end else begin
      prev_r   <= prev_nxt;
      plen_r   <= plen_nxt;
      bitpos_r <= bitpos_nxt;
      sync_r   <= sync_nxt;
      shift_r  <= shift_nxt;
      nbytes_r <= nbytes_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pwbd_checker.sv
// Port-level checks for the demodulator, bound to the top level.
// Depends on assert_macros.svh and pulse_width_byte_demodulator.
`default_nettype none

`include "assert_macros.svh"

module pwbd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [0:0] out_tuser
);

  // stalled result keeps its payload
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser))

  // end marker carries a zero byte
  `ASSERT_IMPL(a_eom_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == 8'd0)

  // with the result slot empty the input side is always open
  `ASSERT_IMPL(a_ready_free, clk, rst_n, !out_tvalid, in_tready)

  // a new result appears only after an item accepted into the input register
  `ASSERT_IMPL(a_rise_cause, clk, rst_n, $rose(out_tvalid), $past(in_tvalid && in_tready, 2))

  // reset empties the result register
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid)

endmodule

bind pulse_width_byte_demodulator pwbd_checker u_pwbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
